>>> rtl/mrme_pkg.sv
// Shared codes and widths for the maze region merge engine.
// No dependencies; imported by maze_region_merge_engine_core.
package mrme_pkg;

    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W    = 5;
    localparam int WALL_W   = 6;
    localparam int COUNT_W  = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 1'b0,
        CFG_COLS = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        KIND_CLEAR   = 1'b0,
        KIND_PROPOSE = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_RIGHT = 2'd2,
        DIR_LEFT  = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        STAT_OPENED   = 2'd0,
        STAT_REJECTED = 2'd1,
        STAT_CLEARED  = 2'd2,
        STAT_UNUSED   = 2'd3
    } status_t;

endpackage

>>> rtl/maze_region_merge_engine_core.sv
// Path from input transaction to m_tvalid: a proposal with a cell off the grid goes from
// ST_IDLE straight to ST_FINISH; one whose cells share a region passes ST_LOOK_OWN,
// ST_LOOK_OTHER and ST_COMPARE first; a clear runs ST_CLEAR over every entry; an accepted merge
// adds ST_SWEEP over every entry and ST_DRAIN; ST_FINISH holds while the output register is full.
// Items are taken one at a time; the label memory's single read port walks every entry once
// per merge, and a clear writes every entry.
// Reset: synchronous, active low; afterwards a clearing pass labels every cell with its own index
// while s_tready stays low. Depends on mrme_pkg.
module maze_region_merge_engine_core #(
    parameter int MAX_ROWS = mrme_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mrme_pkg::MAX_COLS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [mrme_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [mrme_pkg::CFG_W-1:0]          cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mrme_pkg::IN_TDATA_W-1:0]     s_tdata,  // cell_row[4:0], cell_col[9:5], direction[11:10]
    input  logic                                s_tuser,  // kind[0]
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mrme_pkg::OUT_TDATA_W-1:0]    m_tdata,  // wall_row[5:0], wall_col[11:6], maze_done[12]
    output logic [1:0]                          m_tuser   // status[1:0]
);
    import mrme_pkg::*;

    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam int PROD_W = 2 * CFG_W;

    typedef enum logic [8:0] {
        ST_INIT       = 9'b000000001,
        ST_IDLE       = 9'b000000010,
        ST_LOOK_OWN   = 9'b000000100,
        ST_LOOK_OTHER = 9'b000001000,
        ST_COMPARE    = 9'b000010000,
        ST_SWEEP      = 9'b000100000,
        ST_DRAIN      = 9'b001000000,
        ST_CLEAR      = 9'b010000000,
        ST_FINISH     = 9'b100000000
    } state_t;

    // label store
    logic [ADDR_W-1:0] label_mem [CELLS];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] rd_data_reg;

    state_t             state_reg, state_next;
    logic [CFG_W-1:0]   rows_cfg_reg, cols_cfg_reg;
    logic [COUNT_W-1:0] merge_count_reg, merge_count_next;
    logic [ADDR_W-1:0]  scan_reg, scan_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]  own_addr_reg, own_addr_next;
    logic [ADDR_W-1:0]  other_addr_reg, other_addr_next;
    logic [ADDR_W-1:0]  own_lab_reg, own_lab_next;
    logic [ADDR_W-1:0]  other_lab_reg, other_lab_next;
    status_t            status_reg, status_next;
    logic [WALL_W-1:0]  wall_row_reg, wall_row_next;
    logic [WALL_W-1:0]  wall_col_reg, wall_col_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [WALL_W-1:0]  m_wall_row_reg, m_wall_row_next;
    logic [WALL_W-1:0]  m_wall_col_reg, m_wall_col_next;
    logic               m_done_reg, m_done_next;

    // input fields
    logic [POS_W-1:0] in_row, in_col;
    dir_t             in_dir;
    kind_t            in_kind;
    assign in_row  = s_tdata[POS_W-1:0];
    assign in_col  = s_tdata[2*POS_W-1:POS_W];
    assign in_dir  = dir_t'(s_tdata[2*POS_W+1:2*POS_W]);
    assign in_kind = kind_t'(s_tuser);

    // effective grid size
    logic [CFG_W-1:0]  rows_eff, cols_eff;
    logic [PROD_W-1:0] cells_in_use;
    logic [PROD_W:0]   count_plus_one;
    logic              done_now;

    always_comb begin
        if (rows_cfg_reg == '0) begin
            rows_eff = CFG_W'(1);
        end else if (32'(rows_cfg_reg) > MAX_ROWS) begin
            rows_eff = CFG_W'(MAX_ROWS);
        end else begin
            rows_eff = rows_cfg_reg;
        end
        if (cols_cfg_reg == '0) begin
            cols_eff = CFG_W'(1);
        end else if (32'(cols_cfg_reg) > MAX_COLS) begin
            cols_eff = CFG_W'(MAX_COLS);
        end else begin
            cols_eff = cols_cfg_reg;
        end
    end

    assign cells_in_use   = PROD_W'(rows_eff) * PROD_W'(cols_eff);
    assign count_plus_one = (PROD_W+1)'(merge_count_reg) + (PROD_W+1)'(1);
    assign done_now       = (count_plus_one >= {1'b0, cells_in_use});

    // neighbor and bounds check on the incoming proposal
    logic [CFG_W-1:0] r6, c6, nr6, nc6;
    logic             dir_ok, in_ok;

    always_comb begin
        r6     = CFG_W'(in_row);
        c6     = CFG_W'(in_col);
        nr6    = r6;
        nc6    = c6;
        dir_ok = 1'b0;
        unique case (in_dir)
            DIR_UP: begin
                nr6    = r6 - CFG_W'(1);
                dir_ok = (r6 != '0);
            end
            DIR_DOWN: begin
                nr6    = r6 + CFG_W'(1);
                dir_ok = (nr6 < rows_eff);
            end
            DIR_RIGHT: begin
                nc6    = c6 + CFG_W'(1);
                dir_ok = (nc6 < cols_eff);
            end
            DIR_LEFT: begin
                nc6    = c6 - CFG_W'(1);
                dir_ok = (c6 != '0);
            end
            default: begin
                dir_ok = 1'b0;
            end
        endcase
        in_ok = (r6 < rows_eff) && (c6 < cols_eff) && dir_ok;
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        merge_count_next = merge_count_reg;
        scan_next        = scan_reg;
        pend_next        = 1'b0;
        pend_addr_next   = pend_addr_reg;
        own_addr_next    = own_addr_reg;
        other_addr_next  = other_addr_reg;
        own_lab_next     = own_lab_reg;
        other_lab_next   = other_lab_reg;
        status_next      = status_reg;
        wall_row_next    = wall_row_reg;
        wall_col_next    = wall_col_reg;
        m_valid_next     = m_valid_reg;
        m_status_next    = m_status_reg;
        m_wall_row_next  = m_wall_row_reg;
        m_wall_col_next  = m_wall_col_reg;
        m_done_next      = m_done_reg;
        mem_re           = 1'b0;
        mem_raddr        = scan_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT, ST_CLEAR: begin
                scan_next = scan_reg + ADDR_W'(1);
                if (scan_reg == LAST_ADDR) begin
                    scan_next        = '0;
                    merge_count_next = '0;
                    state_next       = (state_reg == ST_INIT) ? ST_IDLE : ST_FINISH;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    wall_row_next   = '0;
                    wall_col_next   = '0;
                    own_addr_next   = ADDR_W'(32'(r6) * MAX_COLS + 32'(c6));
                    other_addr_next = ADDR_W'(32'(nr6) * MAX_COLS + 32'(nc6));
                    if (in_kind == KIND_CLEAR) begin
                        status_next = STAT_CLEARED;
                        scan_next   = '0;
                        state_next  = ST_CLEAR;
                    end else if (!in_ok) begin
                        status_next = STAT_REJECTED;
                        state_next  = ST_FINISH;
                    end else begin
                        status_next   = STAT_OPENED;
                        wall_row_next = r6 + nr6 + WALL_W'(1);
                        wall_col_next = c6 + nc6 + WALL_W'(1);
                        state_next    = ST_LOOK_OWN;
                    end
                end
            end
            ST_LOOK_OWN: begin
                mem_re     = 1'b1;
                mem_raddr  = own_addr_reg;
                state_next = ST_LOOK_OTHER;
            end
            ST_LOOK_OTHER: begin
                mem_re       = 1'b1;
                mem_raddr    = other_addr_reg;
                own_lab_next = rd_data_reg;
                state_next   = ST_COMPARE;
            end
            ST_COMPARE: begin
                if (rd_data_reg == own_lab_reg) begin
                    status_next   = STAT_REJECTED;
                    wall_row_next = '0;
                    wall_col_next = '0;
                    state_next    = ST_FINISH;
                end else begin
                    other_lab_next = rd_data_reg;
                    scan_next      = '0;
                    state_next     = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // read one entry a cycle; the compare and write back act on the registered read data
                mem_re         = 1'b1;
                mem_raddr      = scan_reg;
                pend_next      = 1'b1;
                pend_addr_next = scan_reg;
                scan_next      = scan_reg + ADDR_W'(1);
                if (scan_reg == LAST_ADDR) begin
                    scan_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (merge_count_reg != COUNT_MAX) begin
                    merge_count_next = merge_count_reg + COUNT_W'(1);
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next    = 1'b1;
                    m_status_next   = status_reg;
                    m_wall_row_next = wall_row_reg;
                    m_wall_col_next = wall_col_reg;
                    m_done_next     = done_now;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // write side of the label store
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = scan_reg;
        mem_wdata = scan_reg;
        if ((state_reg == ST_INIT) || (state_reg == ST_CLEAR)) begin
            mem_we = 1'b1;
        end else if (pend_reg && (rd_data_reg == other_lab_reg)) begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_reg;
            mem_wdata = own_lab_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            label_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= label_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_INIT;
            rows_cfg_reg    <= CFG_W'(8);
            cols_cfg_reg    <= CFG_W'(8);
            merge_count_reg <= '0;
            scan_reg        <= '0;
            pend_reg        <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            merge_count_reg <= merge_count_next;
            scan_reg        <= scan_next;
            pend_reg        <= pend_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_addr))
                    CFG_ROWS: rows_cfg_reg <= cfg_wdata;
                    CFG_COLS: cols_cfg_reg <= cfg_wdata;
                    default: begin
                        rows_cfg_reg <= rows_cfg_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg  <= pend_addr_next;
        own_addr_reg   <= own_addr_next;
        other_addr_reg <= other_addr_next;
        own_lab_reg    <= own_lab_next;
        other_lab_reg  <= other_lab_next;
        status_reg     <= status_next;
        wall_row_reg   <= wall_row_next;
        wall_col_reg   <= wall_col_next;
        m_status_reg   <= m_status_next;
        m_wall_row_reg <= m_wall_row_next;
        m_wall_col_reg <= m_wall_col_next;
        m_done_reg     <= m_done_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = OUT_TDATA_W'({m_done_reg, m_wall_col_reg, m_wall_row_reg});

endmodule

>>> bench/maze_region_merge_engine_core_tb.sv
// Testbench for maze_region_merge_engine_core: directed and random wall proposals
// checked against a behavioral label store, with random stalls on both streams.
// Depends on mrme_pkg and maze_region_merge_engine_core.
`timescale 1ns / 100ps

module maze_region_merge_engine_core_tb;
    import mrme_pkg::*;

    localparam int CELL_COUNT       = MAX_ROWS_DEF * MAX_COLS_DEF;
    localparam int TOTAL_ITEMS      = 540;
    localparam int LONG_HOLD_CYCLES = 4000;
    localparam int WATCHDOG_LIMIT   = 20000;
    localparam int DRAIN_CYCLES     = 1100;

    typedef struct packed {
        status_t    status;
        logic [5:0] wall_row;
        logic [5:0] wall_col;
        logic       maze_done;
    } outcome_t;

    typedef struct packed {
        logic [4:0] row;
        logic [4:0] col;
        dir_t       dir;
    } wall_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;   // cell_row[4:0], cell_col[9:5], direction[11:10]
    logic s_tuser;                    // kind[0]
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;  // wall_row[5:0], wall_col[11:6], maze_done[12]
    logic [1:0] m_tuser;              // status[1:0]

    // behavioral copy of the block's state
    logic [9:0] cell_label [0:CELL_COUNT-1];
    logic [COUNT_W-1:0] merges_made;
    logic [CFG_W-1:0] grid_rows;
    logic [CFG_W-1:0] grid_cols;

    outcome_t expected_outcomes[$];
    int mismatch_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int quiet_cycles = 0;
    bit long_hold_req = 1'b0;

    maze_region_merge_engine_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int grid_dim(input logic [CFG_W-1:0] val, input int max_dim);
        if (val == 0) return 1;
        if (val > max_dim) return max_dim;
        return val;
    endfunction

    function automatic void reset_labels();
        for (int a = 0; a < CELL_COUNT; a++) cell_label[a] = 10'(a);
        merges_made = '0;
    endfunction

    // Apply one accepted item to the label store and return the result it must produce.
    function automatic outcome_t predict_outcome(input kind_t kind, input logic [4:0] row,
                                                 input logic [4:0] col, input dir_t dir);
        outcome_t res;
        int er, ec, nr, nc;
        logic [9:0] own, other;
        bit ok;
        er = grid_dim(grid_rows, MAX_ROWS_DEF);
        ec = grid_dim(grid_cols, MAX_COLS_DEF);
        res = '0;
        res.status = STAT_REJECTED;
        if (kind == KIND_CLEAR) begin
            reset_labels();
            res.status = STAT_CLEARED;
        end else begin
            nr = row;
            nc = col;
            ok = (row < er) && (col < ec);
            if (ok) begin
                case (dir)
                    DIR_UP: if (row == 0) ok = 1'b0; else nr = row - 1;
                    DIR_DOWN: begin
                        nr = row + 1;
                        if (nr >= er) ok = 1'b0;
                    end
                    DIR_RIGHT: begin
                        nc = col + 1;
                        if (nc >= ec) ok = 1'b0;
                    end
                    default: if (col == 0) ok = 1'b0; else nc = col - 1;
                endcase
            end
            if (ok) begin
                own = cell_label[row * MAX_COLS_DEF + col];
                other = cell_label[nr * MAX_COLS_DEF + nc];
                ok = (own != other);
            end
            if (ok) begin
                // the whole store is relabeled, cells outside the grid included
                for (int a = 0; a < CELL_COUNT; a++)
                    if (cell_label[a] == other) cell_label[a] = own;
                if (merges_made < COUNT_MAX) merges_made = merges_made + 1'b1;
                res.status = STAT_OPENED;
                res.wall_row = 6'(row + nr + 1);
                res.wall_col = 6'(col + nc + 1);
            end
        end
        res.maze_done = (merges_made + 1 >= er * ec);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Present one item and hold it until the block takes it; tvalid is left high.
    task automatic send_item(input kind_t kind, input logic [4:0] row, input logic [4:0] col,
                             input dir_t dir);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'b0, dir, col, row};
        do @(posedge aclk); while (s_tready !== 1'b1);
        expected_outcomes.push_back(predict_outcome(kind, row, col, dir));
        items_sent++;
    endtask

    // Send within a burst; at the end of a burst drop tvalid for a random gap.
    task automatic offer_item(input kind_t kind, input logic [4:0] row, input logic [4:0] col,
                              input dir_t dir);
        int gap;
        send_item(kind, row, col, dir);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 1500)
                                               : $urandom_range(1, 10);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge aclk);
    endtask

    // Only called with the block idle.
    task automatic set_grid(input logic [CFG_W-1:0] rows_val, input logic [CFG_W-1:0] cols_val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_ROWS;
        cfg_wdata <= rows_val;
        @(negedge aclk);
        cfg_addr <= CFG_COLS;
        cfg_wdata <= cols_val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        grid_rows = rows_val;
        grid_cols = cols_val;
    endtask

    // Propose up to max_walls interior walls of the current grid in shuffled order, each from a
    // random side, optionally mixed with arbitrary items.
    task automatic run_kruskal_pass(input int max_walls, input bit noisy, input bit bursty);
        wall_t walls[$];
        wall_t w, tmp;
        int er, ec, j;
        kind_t kind;
        er = grid_dim(grid_rows, MAX_ROWS_DEF);
        ec = grid_dim(grid_cols, MAX_COLS_DEF);
        for (int r = 0; r < er; r++) begin
            for (int c = 0; c < ec; c++) begin
                if (c + 1 < ec) walls.push_back({5'(r), 5'(c), DIR_RIGHT});
                if (r + 1 < er) walls.push_back({5'(r), 5'(c), DIR_DOWN});
            end
        end
        for (int i = walls.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = walls[i];
            walls[i] = walls[j];
            walls[j] = tmp;
        end
        for (int i = 0; i < walls.size() && i < max_walls; i++) begin
            if (noisy && $urandom_range(0, 9) == 0) begin
                kind = ($urandom_range(0, 19) == 0) ? KIND_CLEAR : KIND_PROPOSE;
                if (bursty)
                    offer_item(kind, 5'($urandom), 5'($urandom), dir_t'($urandom_range(0, 3)));
                else
                    send_item(kind, 5'($urandom), 5'($urandom), dir_t'($urandom_range(0, 3)));
            end
            w = walls[i];
            // propose from the far side half of the time
            if ($urandom_range(0, 1) == 1) begin
                if (w.dir == DIR_RIGHT) begin
                    w.col = w.col + 1'b1;
                    w.dir = DIR_LEFT;
                end else begin
                    w.row = w.row + 1'b1;
                    w.dir = DIR_UP;
                end
            end
            if (bursty) offer_item(KIND_PROPOSE, w.row, w.col, w.dir);
            else send_item(KIND_PROPOSE, w.row, w.col, w.dir);
        end
    endtask

    task automatic test_directed_moves();
        offer_item(KIND_PROPOSE, 3, 3, DIR_UP);
        offer_item(KIND_PROPOSE, 3, 3, DIR_DOWN);
        offer_item(KIND_PROPOSE, 3, 3, DIR_RIGHT);
        offer_item(KIND_PROPOSE, 3, 3, DIR_LEFT);
        offer_item(KIND_PROPOSE, 2, 3, DIR_DOWN);   // already one region
        offer_item(KIND_PROPOSE, 0, 0, DIR_UP);
        offer_item(KIND_PROPOSE, 0, 0, DIR_LEFT);
        offer_item(KIND_PROPOSE, 7, 7, DIR_DOWN);
        offer_item(KIND_PROPOSE, 7, 7, DIR_RIGHT);
        offer_item(KIND_PROPOSE, 31, 31, DIR_LEFT); // cell outside the grid
        offer_item(KIND_PROPOSE, 8, 0, DIR_UP);
        offer_item(KIND_CLEAR, 31, 31, DIR_LEFT);
        offer_item(KIND_PROPOSE, 3, 3, DIR_UP);
    endtask

    task automatic test_register_extremes();
        wait_drain();
        set_grid(6'd0, 6'd0);                        // acts as a single cell
        offer_item(KIND_CLEAR, 0, 0, DIR_UP);
        offer_item(KIND_PROPOSE, 0, 0, DIR_RIGHT);
        wait_drain();
        set_grid(6'd63, 6'd63);                      // clamps to the full array
        offer_item(KIND_PROPOSE, 31, 31, DIR_UP);
        offer_item(KIND_PROPOSE, 31, 31, DIR_LEFT);
        offer_item(KIND_PROPOSE, 31, 0, DIR_RIGHT);
    endtask

    task automatic test_grid_shrink();
        wait_drain();
        set_grid(6'd2, 6'd2);
        offer_item(KIND_CLEAR, 0, 0, DIR_UP);
        offer_item(KIND_PROPOSE, 0, 0, DIR_RIGHT);
        offer_item(KIND_PROPOSE, 0, 0, DIR_DOWN);
        offer_item(KIND_PROPOSE, 1, 1, DIR_UP);
        wait_drain();
        // merge count now exceeds cells minus one
        set_grid(6'd1, 6'd2);
        offer_item(KIND_PROPOSE, 0, 0, DIR_RIGHT);
    endtask

    task automatic test_backpressure();
        wait_drain();
        set_grid(6'd3, 6'd3);
        long_hold_req = 1'b1;
        send_item(KIND_CLEAR, 0, 0, DIR_UP);
        run_kruskal_pass(12, 1'b0, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_grids();
        logic [CFG_W-1:0] rows_val, cols_val;
        while (items_sent < TOTAL_ITEMS) begin
            wait_drain();
            case ($urandom_range(0, 7))
                0: begin
                    rows_val = ($urandom_range(0, 1) == 1) ? 6'd63 : 6'd0;
                    cols_val = 6'($urandom_range(1, 6));
                end
                1: begin
                    rows_val = 6'($urandom_range(1, 6));
                    cols_val = 6'($urandom_range(33, 63));
                end
                2: begin
                    rows_val = 6'($urandom_range(1, 32));
                    cols_val = 6'($urandom_range(1, 32));
                end
                default: begin
                    rows_val = 6'($urandom_range(1, 6));
                    cols_val = 6'($urandom_range(1, 6));
                end
            endcase
            set_grid(rows_val, cols_val);
            // keep old labels across the size change now and then
            if ($urandom_range(0, 3) != 0)
                offer_item(KIND_CLEAR, 5'($urandom), 5'($urandom), dir_t'($urandom_range(0, 3)));
            run_kruskal_pass(60, 1'b1, 1'b1);
        end
    endtask

    // Result side: stall pattern of its own, plus one long hold on request.
    initial begin : result_sink
        int run_left;
        int mode;
        run_left = 0;
        mode = 0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                long_hold_req = 1'b0;
            end
            if (run_left == 0) begin
                mode = $urandom_range(0, 3);
                run_left = $urandom_range(1, 50);
            end
            run_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (expected_outcomes.size() == 0) begin
                report_mismatch($sformatf("unexpected result tdata=%h tuser=%h",
                                          m_tdata, m_tuser));
            end else begin
                want = expected_outcomes.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              m_tuser, want.status));
                if (m_tdata[5:0] !== want.wall_row)
                    report_mismatch($sformatf("wall_row got %0d want %0d",
                                              m_tdata[5:0], want.wall_row));
                if (m_tdata[11:6] !== want.wall_col)
                    report_mismatch($sformatf("wall_col got %0d want %0d",
                                              m_tdata[11:6], want.wall_col));
                if (m_tdata[12] !== want.maze_done)
                    report_mismatch($sformatf("maze_done got %0d want %0d",
                                              m_tdata[12], want.maze_done));
            end
        end
    end

    // Count cycles without any transaction on either stream.
    always @(posedge aclk) begin
        if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, quiet_cycles);
            $display("maze_region_merge_engine_core_tb failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = CFG_ROWS;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_CLEAR;
        m_tready = 1'b0;
        grid_rows = 6'd8;
        grid_cols = 6'd8;
        reset_labels();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_moves();
        test_register_extremes();
        test_grid_shrink();
        test_backpressure();
        test_random_grids();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("maze_region_merge_engine_core_tb passed");
        else
            $display("maze_region_merge_engine_core_tb failed");
        $finish;
    end

endmodule

>>> maze_region_merge_engine_core.f
rtl/mrme_pkg.sv
rtl/maze_region_merge_engine_core.sv
bench/maze_region_merge_engine_core_tb.sv
